// ===== rtl/core/cua_pkg.sv =====
// Shared types and constants for the CPU utilization admission block.
// Used by the arithmetic unit, the datapath, the controller and the top level.
package cua_pkg;

  localparam int TIME_W = 48;
  localparam int TASK_W = 40;
  localparam int WIDE_W = 96;
  localparam int LIMIT_W = 7;
  localparam int CMP_W = 55;

  localparam logic [TIME_W-1:0] BASE_RESET = 48'd1000;
  localparam logic [TIME_W-1:0] US_NS = 48'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd90;
  localparam logic [CMP_W-1:0] PERCENT = 55'd100;

  typedef enum logic [1:0] {
    STAT_FIT,
    STAT_REALIGN,
    STAT_NOSPACE,
    STAT_ERR
  } status_t;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_GCD
  } aop_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_PER_US,
    ST_BASE_US,
    ST_BASE_DL,
    ST_GCD,
    ST_Q,
    ST_NB,
    ST_FACTOR,
    ST_SCALE,
    ST_PROD,
    ST_SHARE,
    ST_SUM,
    ST_CMP,
    ST_COMMIT,
    ST_FIN
  } step_t;

  typedef struct packed {
    step_t step;
    logic  go;
    logic  take;
  } dp_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic err;
    logic realign;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/core/cua_arith.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and binary gcd.
// Depends on cua_pkg.
module cua_arith (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start_i,
  input  cua_pkg::aop_t                   op_i,
  input  logic [cua_pkg::WIDE_W-1:0]      a_i,
  input  logic [cua_pkg::TIME_W-1:0]      b_i,
  output logic                            done_o,
  output logic [cua_pkg::WIDE_W-1:0]      res_o,
  output logic [cua_pkg::TIME_W-1:0]      rem_o
);

  localparam int MUL_STEPS = cua_pkg::TIME_W;
  localparam int DIV_STEPS = cua_pkg::WIDE_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  cua_pkg::aop_t                 op_r, op_nxt;
  logic [cua_pkg::WIDE_W-1:0]    x_r, x_nxt;
  logic [cua_pkg::WIDE_W-1:0]    y_r, y_nxt;
  logic [cua_pkg::TIME_W:0]      z_r, z_nxt;
  logic [6:0]                    cnt_r, cnt_nxt;
  logic [5:0]                    k_r, k_nxt;
  logic [cua_pkg::TIME_W:0]      rs;
  logic [cua_pkg::TIME_W-1:0]    ga, gb, gdiff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    rs       = {z_r[cua_pkg::TIME_W-1:0], x_r[cua_pkg::WIDE_W-1]};
    ga       = x_r[cua_pkg::TIME_W-1:0];
    gb       = z_r[cua_pkg::TIME_W-1:0];
    gdiff    = (ga >= gb) ? (ga - gb) : (gb - ga);
    if (start_i) begin
      busy_nxt = 1'b1;
      op_nxt   = op_i;
      cnt_nxt  = '0;
      k_nxt    = '0;
      y_nxt    = '0;
      case (op_i)
        cua_pkg::AOP_MUL: begin
          x_nxt = '0;
          y_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, a_i[cua_pkg::TIME_W-1:0]};
          z_nxt = {1'b0, b_i};
        end
        cua_pkg::AOP_DIV: begin
          x_nxt = a_i;
          y_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, b_i};
          z_nxt = '0;
        end
        default: begin
          x_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, a_i[cua_pkg::TIME_W-1:0]};
          z_nxt = {1'b0, b_i};
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        cua_pkg::AOP_MUL: begin
          if (z_r[0]) begin
            x_nxt = x_r + y_r;
          end
          y_nxt   = y_r << 1;
          z_nxt   = z_r >> 1;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'(MUL_STEPS - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        cua_pkg::AOP_DIV: begin
          if (rs >= {1'b0, y_r[cua_pkg::TIME_W-1:0]}) begin
            z_nxt = rs - {1'b0, y_r[cua_pkg::TIME_W-1:0]};
            x_nxt = {x_r[cua_pkg::WIDE_W-2:0], 1'b1};
          end else begin
            z_nxt = rs;
            x_nxt = {x_r[cua_pkg::WIDE_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          if (ga == '0 || gb == '0) begin
            x_nxt    = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, ga | gb} << k_r;
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else if (!ga[0] && !gb[0]) begin
            x_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, ga >> 1};
            z_nxt = {1'b0, gb >> 1};
            k_nxt = k_r + 6'd1;
          end else if (!ga[0]) begin
            x_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, ga >> 1};
          end else if (!gb[0]) begin
            z_nxt = {1'b0, gb >> 1};
          end else if (ga >= gb) begin
            x_nxt = {{(cua_pkg::WIDE_W-cua_pkg::TIME_W){1'b0}}, gdiff >> 1};
          end else begin
            z_nxt = {1'b0, gdiff >> 1};
          end
        end
      endcase
    end
  end

  assign done_o = done_r;
  assign res_o  = x_r;
  assign rem_o  = z_r[cua_pkg::TIME_W-1:0];

endmodule

// ===== rtl/core/cua_datapath.sv =====
// Datapath: per-CPU table, item registers, limit register, result register and arithmetic.
// Depends on cua_pkg and cua_arith.
module cua_datapath #(
  parameter int NUM_CPUS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cua_pkg::dp_cmd_t              cmd_i,
  output cua_pkg::dp_stat_t             stat_o,
  input  logic                          op_i,
  input  logic [3:0]                    cpu_i,
  input  logic [cua_pkg::TASK_W-1:0]    runtime_i,
  input  logic [cua_pkg::TASK_W-1:0]    period_i,
  input  logic [cua_pkg::TASK_W-1:0]    deadline_i,
  input  logic                          cfg_valid_i,
  input  logic [cua_pkg::LIMIT_W-1:0]   cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output cua_pkg::status_t              out_status_o,
  output logic [cua_pkg::TIME_W-1:0]    out_base_o,
  output logic [cua_pkg::TIME_W-1:0]    out_used_o
);

  localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int TW = cua_pkg::TIME_W;

  logic [2*TW-1:0]              mem [NUM_CPUS];
  logic [NUM_CPUS-1:0]          valid_r;
  logic [2*TW-1:0]              rd_r;
  logic                         rd_vld_r;
  logic                         op_r;
  logic [3:0]                   cpu_r;
  logic [cua_pkg::TASK_W-1:0]   rt_r, per_r, dl_r;
  logic [TW-1:0]                base_r, used_r, obase_r, oused_r;
  logic [TW-1:0]                g_r, q_r, nb_r, f_r, share_r, total_r;
  logic [cua_pkg::WIDE_W-1:0]   prod_r;
  logic [cua_pkg::CMP_W-1:0]    lhs_r, rhs_r;
  logic                         err_r, bad_r;
  cua_pkg::status_t             st_r;
  logic [cua_pkg::LIMIT_W-1:0]  limit_r;
  logic                         out_valid_r;
  cua_pkg::status_t             out_status_r;
  logic [TW-1:0]                out_base_r, out_used_r;
  logic [15:0]                  m_s_r;
  logic                         m_lo_r, m_vld_r, m_done_r, m_bad_r;

  logic [IDX_W-1:0]             idx;
  logic                         bad_cpu;
  logic [TW-1:0]                ld_base, ld_used;
  logic                         a_start, a_done;
  cua_pkg::aop_t                a_op;
  logic [cua_pkg::WIDE_W-1:0]   a_a, a_res;
  logic [TW-1:0]                a_b, a_rem;
  logic                         res_hi;
  logic [TW:0]                  sum;
  logic                         fin_take, commit;
  logic                         m_go;
  logic [TW-1:0]                m_x;
  logic [10:0]                  m_t;
  logic [8:0]                   m_u;

  // Folds a 48-bit value to a 16-bit one with the same remainder modulo 125.
  // Byte i carries the weight 256**i modulo 125.
  function automatic logic [15:0] fold125(logic [TW-1:0] x);
    return 16'(x[7:0]) + 16'(x[15:8]) * 16'd6 + 16'(x[23:16]) * 16'd36 +
           16'(x[31:24]) * 16'd91 + 16'(x[39:32]) * 16'd46 + 16'(x[47:40]) * 16'd26;
  endfunction

  assign idx     = IDX_W'(cpu_r);
  assign bad_cpu = 32'(cpu_r) >= NUM_CPUS;
  assign ld_base = rd_vld_r ? rd_r[TW-1:0] : cua_pkg::BASE_RESET;
  assign ld_used = rd_vld_r ? rd_r[2*TW-1:TW] : '0;
  assign res_hi  = |a_res[cua_pkg::WIDE_W-1:TW];
  assign sum     = {1'b0, used_r} + {1'b0, share_r};
  assign fin_take = cmd_i.take && cmd_i.step == cua_pkg::ST_FIN;
  assign commit  = cmd_i.take && cmd_i.step == cua_pkg::ST_COMMIT && op_r;

  assign m_go = cmd_i.go &&
                (cmd_i.step == cua_pkg::ST_PER_US || cmd_i.step == cua_pkg::ST_BASE_US);
  assign m_x  = (cmd_i.step == cua_pkg::ST_PER_US) ? TW'(per_r) : base_r;
  assign m_t  = 11'(m_s_r[15:8]) * 11'd6 + 11'(m_s_r[7:0]);
  assign m_u  = 9'(m_t[10:8]) * 9'd6 + 9'(m_t[7:0]);

  always_comb begin
    a_start = cmd_i.go;
    a_op    = cua_pkg::AOP_DIV;
    a_a     = cua_pkg::WIDE_W'(base_r);
    a_b     = cua_pkg::US_NS;
    case (cmd_i.step)
      cua_pkg::ST_BASE_DL: a_b = TW'(dl_r);
      cua_pkg::ST_GCD: begin
        a_op = cua_pkg::AOP_GCD;
        a_b  = TW'(per_r);
      end
      cua_pkg::ST_Q: a_b = g_r;
      cua_pkg::ST_NB: begin
        a_op = cua_pkg::AOP_MUL;
        a_a  = cua_pkg::WIDE_W'(q_r);
        a_b  = TW'(per_r);
      end
      cua_pkg::ST_FACTOR: begin
        a_a = cua_pkg::WIDE_W'(per_r);
        a_b = g_r;
      end
      cua_pkg::ST_SCALE: begin
        a_op = cua_pkg::AOP_MUL;
        a_a  = cua_pkg::WIDE_W'(used_r);
        a_b  = f_r;
      end
      cua_pkg::ST_PROD: begin
        a_op = cua_pkg::AOP_MUL;
        a_a  = cua_pkg::WIDE_W'(rt_r);
        a_b  = base_r;
      end
      cua_pkg::ST_SHARE: begin
        a_a = prod_r;
        a_b = TW'(per_r);
      end
      default: a_start = 1'b0;
    endcase
  end

  cua_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (a_start),
    .op_i    (a_op),
    .a_i     (a_a),
    .b_i     (a_b),
    .done_o  (a_done),
    .res_o   (a_res),
    .rem_o   (a_rem)
  );

  always_ff @(posedge clk) begin
    if (commit) begin
      mem[idx] <= {total_r, base_r};
    end
    if (cmd_i.take && cmd_i.step == cua_pkg::ST_READ) begin
      rd_r <= mem[idx];
    end
  end

  // A whole number of microseconds needs the low three bits clear and a zero
  // remainder modulo 125; the folded residue is at most 285.
  always_ff @(posedge clk) begin
    if (m_go) begin
      m_s_r  <= fold125(m_x);
      m_lo_r <= |m_x[2:0];
    end
    if (m_vld_r) begin
      m_bad_r <= m_lo_r || !(m_u == 9'd0 || m_u == 9'd125 || m_u == 9'd250);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      limit_r     <= cua_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
      m_vld_r     <= 1'b0;
      m_done_r    <= 1'b0;
    end else begin
      m_vld_r  <= m_go;
      m_done_r <= m_vld_r;
      if (commit) begin
        valid_r[idx] <= 1'b1;
      end
      if (cfg_valid_i) begin
        limit_r <= cfg_data_i;
      end
      if (fin_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      case (cmd_i.step)
        cua_pkg::ST_IDLE: begin
          op_r  <= op_i;
          cpu_r <= cpu_i;
          rt_r  <= runtime_i;
          per_r <= period_i;
          dl_r  <= deadline_i;
          st_r  <= cua_pkg::STAT_FIT;
        end
        cua_pkg::ST_READ: rd_vld_r <= valid_r[idx];
        cua_pkg::ST_LOAD: begin
          base_r  <= ld_base;
          used_r  <= ld_used;
          obase_r <= ld_base;
          oused_r <= ld_used;
          bad_r   <= bad_cpu;
          err_r   <= per_r == '0 || dl_r == '0 || ld_base == '0;
        end
        cua_pkg::ST_PER_US, cua_pkg::ST_BASE_US: begin
          if (m_bad_r) begin
            err_r <= 1'b1;
          end
        end
        cua_pkg::ST_GCD: g_r <= a_res[TW-1:0];
        cua_pkg::ST_Q: q_r <= a_res[TW-1:0];
        cua_pkg::ST_NB: begin
          if (res_hi) begin
            err_r <= 1'b1;
          end
          nb_r <= a_res[TW-1:0];
        end
        cua_pkg::ST_FACTOR: f_r <= a_res[TW-1:0];
        cua_pkg::ST_SCALE: begin
          if (res_hi) begin
            err_r <= 1'b1;
          end else begin
            used_r <= a_res[TW-1:0];
            base_r <= nb_r;
            st_r   <= cua_pkg::STAT_REALIGN;
          end
        end
        cua_pkg::ST_PROD: prod_r <= a_res;
        cua_pkg::ST_SHARE: begin
          if (res_hi) begin
            err_r <= 1'b1;
          end
          share_r <= a_res[TW-1:0];
        end
        cua_pkg::ST_SUM: begin
          if (sum[TW]) begin
            err_r <= 1'b1;
          end
          total_r <= sum[TW-1:0];
        end
        cua_pkg::ST_CMP: begin
          lhs_r <= cua_pkg::CMP_W'(total_r) * cua_pkg::PERCENT;
          rhs_r <= cua_pkg::CMP_W'(limit_r) * cua_pkg::CMP_W'(base_r);
        end
        cua_pkg::ST_COMMIT: begin
          if (lhs_r > rhs_r) begin
            st_r <= cua_pkg::STAT_NOSPACE;
          end
        end
        cua_pkg::ST_FIN: begin
          if (bad_r) begin
            out_status_r <= cua_pkg::STAT_ERR;
            out_base_r   <= '0;
            out_used_r   <= '0;
          end else if (err_r) begin
            out_status_r <= cua_pkg::STAT_ERR;
            out_base_r   <= obase_r;
            out_used_r   <= oused_r;
          end else begin
            out_status_r <= st_r;
            out_base_r   <= op_r ? base_r : obase_r;
            out_used_r   <= op_r ? total_r : oused_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.arith_done = a_done | m_done_r;
  assign stat_o.err        = err_r | bad_r;
  assign stat_o.realign    = a_rem != '0;
  assign stat_o.out_busy   = out_valid_r && !out_ready_i;

  assign out_valid_o  = out_valid_r;
  assign out_status_o = out_status_r;
  assign out_base_o   = out_base_r;
  assign out_used_o   = out_used_r;

endmodule

// ===== rtl/core/cua_ctrl.sv =====
// Controller state machine that sequences one admission item through the datapath.
// Depends on cua_pkg.
module cua_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cua_pkg::dp_stat_t  stat_i,
  output cua_pkg::dp_cmd_t   cmd_o
);

  cua_pkg::step_t state_r, state_nxt;
  logic           started_r, started_nxt;
  cua_pkg::step_t after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cua_pkg::ST_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end

  always_comb begin
    case (state_r)
      cua_pkg::ST_PER_US:  after = cua_pkg::ST_BASE_US;
      cua_pkg::ST_BASE_US: after = cua_pkg::ST_BASE_DL;
      cua_pkg::ST_BASE_DL: after = stat_i.realign ? cua_pkg::ST_GCD : cua_pkg::ST_PROD;
      cua_pkg::ST_GCD:     after = cua_pkg::ST_Q;
      cua_pkg::ST_Q:       after = cua_pkg::ST_NB;
      cua_pkg::ST_NB:      after = cua_pkg::ST_FACTOR;
      cua_pkg::ST_FACTOR:  after = cua_pkg::ST_SCALE;
      cua_pkg::ST_SCALE:   after = cua_pkg::ST_PROD;
      cua_pkg::ST_PROD:    after = cua_pkg::ST_SHARE;
      cua_pkg::ST_SHARE:   after = cua_pkg::ST_SUM;
      cua_pkg::ST_SUM:     after = cua_pkg::ST_CMP;
      cua_pkg::ST_CMP:     after = cua_pkg::ST_COMMIT;
      default:             after = cua_pkg::ST_FIN;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    cmd_o.step   = state_r;
    cmd_o.go     = 1'b0;
    cmd_o.take   = 1'b0;
    in_ready_o   = state_r == cua_pkg::ST_IDLE;
    case (state_r)
      cua_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_nxt  = cua_pkg::ST_READ;
        end
      end
      cua_pkg::ST_READ: begin
        cmd_o.take = 1'b1;
        state_nxt  = cua_pkg::ST_LOAD;
      end
      cua_pkg::ST_LOAD: begin
        cmd_o.take = 1'b1;
        state_nxt  = cua_pkg::ST_PER_US;
      end
      cua_pkg::ST_SUM, cua_pkg::ST_CMP, cua_pkg::ST_COMMIT: begin
        if (stat_i.err) begin
          state_nxt = cua_pkg::ST_FIN;
        end else begin
          cmd_o.take = 1'b1;
          state_nxt  = after;
        end
      end
      cua_pkg::ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.take = 1'b1;
          state_nxt  = cua_pkg::ST_IDLE;
        end
      end
      default: begin
        if (stat_i.err) begin
          state_nxt   = cua_pkg::ST_FIN;
          started_nxt = 1'b0;
        end else if (!started_r) begin
          cmd_o.go    = 1'b1;
          started_nxt = 1'b1;
        end else if (stat_i.arith_done) begin
          cmd_o.take  = 1'b1;
          started_nxt = 1'b0;
          state_nxt   = after;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/cpu_utilization_admission.sv =====
// Top level of the CPU utilization admission block.
// Depends on cua_pkg, cua_ctrl and cua_datapath.
//
// Channel  Direction  Beat contents
// in       slave      tuser: operation; tdata: cpu_index, runtime, period, deadline
// out      master     tuser: status; tdata: base_after, used_after
// cfg      slave      data: limit_percent (always ready)
//
// One item at a time; each item runs on the shared bit-serial unit (two 96-step divides and
// one 48-step multiply, plus a gcd of up to about 100 steps, two more divides and two
// multiplies on realign).
// Each whole-microsecond check registers the folded value, then the verdict with its done flag.
// A synchronous active-low reset restores every CPU entry to base 1000, used 0.
// A finished result waits in the output register; a stalled result holds the next item at FIN.
module cpu_utilization_admission #(
  parameter int NUM_CPUS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // cpu_index[3:0], task_runtime[43:4], task_period[83:44],
                                   // task_deadline[123:84], zero fill
  input  logic [0:0]   in_tuser,   // operation[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // base_after[47:0], used_after[95:48]
  output logic [1:0]   out_tuser,  // status[1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  cua_pkg::dp_cmd_t  cmd;
  cua_pkg::dp_stat_t stat;
  cua_pkg::status_t  out_status;

  assign cfg_ready = 1'b1;

  cua_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cua_datapath #(
    .NUM_CPUS (NUM_CPUS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (in_tuser[0]),
    .cpu_i        (in_tdata[3:0]),
    .runtime_i    (in_tdata[43:4]),
    .period_i     (in_tdata[83:44]),
    .deadline_i   (in_tdata[123:84]),
    .cfg_valid_i  (cfg_valid),
    .cfg_data_i   (cfg_data),
    .out_ready_i  (out_tready),
    .out_valid_o  (out_tvalid),
    .out_status_o (out_status),
    .out_base_o   (out_tdata[47:0]),
    .out_used_o   (out_tdata[95:48])
  );

  assign out_tuser = out_status;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready
  ) else $error("input accepted again right after a beat");

  a_good_result_base: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != cua_pkg::STAT_ERR) |-> (out_tdata[47:0] != 48'd0)
  ) else $error("successful result with zero base period");

  a_result_needs_item: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready)
  ) else $error("result appeared without an item in flight");

endmodule

// ===== bench/cpu_utilization_admission_tb.sv =====
// Testbench for the CPU utilization admission block: directed table, then random tasks.
// Every result is checked against a local model of the per-CPU base and used-time table.
// Depends on cua_pkg and the cpu_utilization_admission top level.
`timescale 1ns / 1ps

module cpu_utilization_admission_tb;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    cua_pkg::status_t st;
    logic [47:0]      base;
    logic [47:0]      used;
  } verdict_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  cpu;
    logic [39:0] runtime;
    logic [39:0] period;
    logic [39:0] deadline;
    logic        typed;
    verdict_t    want;
  } task_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [6:0]   cfg_data = '0;

  logic [47:0] cpu_base [16];
  logic [47:0] cpu_used [16];
  logic [6:0]  limit_pct;
  verdict_t    verdicts [$];
  int          failures = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          status_seen [4];

  cpu_utilization_admission dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [47:0] gcd48(logic [47:0] a, logic [47:0] b);
    logic [47:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  // Evaluates one task against the table, commits it on add, returns the expected beat.
  function automatic verdict_t admit_task(logic op, logic [3:0] cpu, logic [39:0] runtime,
                                          logic [39:0] period, logic [39:0] deadline);
    logic [127:0]     base;
    logic [127:0]     used;
    logic [127:0]     nb;
    logic [127:0]     factor;
    logic [127:0]     share;
    logic [127:0]     total;
    logic             bad;
    cua_pkg::status_t st;
    verdict_t         v;
    base = 128'(cpu_base[cpu]);
    used = 128'(cpu_used[cpu]);
    bad = 1'b0;
    st = cua_pkg::STAT_FIT;
    if (period == 0 || deadline == 0 || period % 1000 != 0 || base == 0 ||
        base % 1000 != 0) begin
      bad = 1'b1;
    end else if (base % deadline != 0) begin
      nb = (base / gcd48(base[47:0], 48'(period))) * period;
      if (nb > MAX48) begin
        bad = 1'b1;
      end else begin
        factor = nb / base;
        if (used * factor > MAX48) begin
          bad = 1'b1;
        end else begin
          used = used * factor;
          base = nb;
          st = cua_pkg::STAT_REALIGN;
        end
      end
    end
    if (!bad) begin
      share = (runtime * base) / period;
      total = used + share;
      if (share > MAX48 || total > MAX48) begin
        bad = 1'b1;
      end else begin
        if (total * 100 > limit_pct * base) st = cua_pkg::STAT_NOSPACE;
        if (op) begin
          cpu_base[cpu] = base[47:0];
          cpu_used[cpu] = total[47:0];
        end
      end
    end
    v.st = bad ? cua_pkg::STAT_ERR : st;
    v.base = cpu_base[cpu];
    v.used = cpu_used[cpu];
    return v;
  endfunction

  task automatic send_task(task_row_t r);
    verdict_t v;
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {4'b0, r.deadline, r.period, r.runtime, r.cpu};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = admit_task(r.op, r.cpu, r.runtime, r.period, r.deadline);
    if (r.typed && v != r.want) begin
      $display("%0t table row disagrees: typed %0d/%0d/%0d, model %0d/%0d/%0d", $time,
               r.want.st, r.want.base, r.want.used, v.st, v.base, v.used);
      failures++;
    end
    verdicts.push_back(r.typed ? r.want : v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic idle_then_set_limit(logic [6:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_pct = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic task_row_t random_task();
    task_row_t r;
    logic [39:0] k;
    r = '0;
    r.op = ($urandom_range(0, 99) < 40);
    r.cpu = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      r.runtime = rand40();
      r.period = rand40();
      r.deadline = rand40();
      if ($urandom_range(0, 1)) r.period = (r.period / 40'd1000) * 40'd1000;
    end else begin
      k = 40'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 20)
                                           : $urandom_range(1, 20));
      r.period = k * 40'd1000;
      case ($urandom_range(0, 3))
        0: r.deadline = 40'd1000;
        1: r.deadline = r.period;
        2: r.deadline = 40'd500;
        default: r.deadline = 40'($urandom_range(1, 100000));
      endcase
      r.runtime = 40'($urandom_range(0, 32'(r.period / 40'd4)));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t w;
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser]++;
      if (verdicts.size() == 0) begin
        $display("%0t unexpected beat: status %0d base %0d used %0d", $time, out_tuser,
                 out_tdata[47:0], out_tdata[95:48]);
        failures++;
      end else begin
        w = verdicts.pop_front();
        if (out_tuser != w.st) begin
          $display("%0t status: expected %0d, got %0d", $time, w.st, out_tuser);
          failures++;
        end
        if (out_tdata[47:0] != w.base) begin
          $display("%0t base_after: expected %0d, got %0d", $time, w.base, out_tdata[47:0]);
          failures++;
        end
        if (out_tdata[95:48] != w.used) begin
          $display("%0t used_after: expected %0d, got %0d", $time, w.used,
                   out_tdata[95:48]);
          failures++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("%0t run timed out with %0d beats pending", $time, verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    task_row_t rows [$];
    task_row_t r;
    int phase;
    for (int i = 0; i < 16; i++) begin
      cpu_base[i] = 48'd1000;
      cpu_used[i] = '0;
    end
    limit_pct = 7'd90;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // op, cpu, runtime, period, deadline, typed, expected
    rows.push_back('{0, 0, 0, 1000, 1000, 1, '{cua_pkg::STAT_FIT, 1000, 0}});
    rows.push_back('{0, 0, 5, 0, 1000, 1, '{cua_pkg::STAT_ERR, 1000, 0}});
    rows.push_back('{0, 0, 5, 1000, 0, 1, '{cua_pkg::STAT_ERR, 1000, 0}});
    rows.push_back('{1, 0, 5, 1500, 1000, 1, '{cua_pkg::STAT_ERR, 1000, 0}});
    rows.push_back('{1, 1, 500, 1000, 1000, 1, '{cua_pkg::STAT_FIT, 1000, 500}});
    rows.push_back('{1, 1, 500, 1000, 1000, 1, '{cua_pkg::STAT_NOSPACE, 1000, 1000}});
    rows.push_back('{0, 2, 0, 3000, 3000, 1, '{cua_pkg::STAT_REALIGN, 1000, 0}});
    rows.push_back('{1, 2, 0, 3000, 3000, 1, '{cua_pkg::STAT_REALIGN, 3000, 0}});
    rows.push_back('{1, 3, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 1,
                     '{cua_pkg::STAT_ERR, 1000, 0}});
    rows.push_back('{0, 4, 40'hFFFFFFFFFF, 40'd1099511627000, 40'hFFFFFFFFFF, 0, '0});
    rows.push_back('{1, 5, 1, 40'd999999000, 7, 0, '0});
    rows.push_back('{1, 5, 7, 40'd999983000, 3, 0, '0});
    rows.push_back('{1, 5, 40'hFFFFFFFFFF, 1000, 1000, 0, '0});
    rows.push_back('{1, 6, 40'hFFFFFFFFFF, 1000, 1000, 0, '0});
    rows.push_back('{1, 15, 300, 2000, 500, 0, '{cua_pkg::STAT_FIT, 0, 0}});
    rows.push_back('{1, 15, 1, 7000, 7000, 0, '0});
    rows.push_back('{0, 15, 40'h5555555555, 40'hAAAAAAAA00, 40'h5555555555, 0, '0});
    foreach (rows[i]) send_task(rows[i]);

    idle_then_set_limit(7'd100);
    send_task('{0, 1, 0, 1000, 1000, 0, '0});
    send_task('{0, 1, 1, 1000, 1000, 0, '0});
    idle_then_set_limit(7'd1);
    send_task('{0, 0, 10, 1000, 1000, 0, '0});
    send_task('{0, 0, 11, 1000, 1000, 0, '0});
    idle_then_set_limit(7'd0);
    send_task('{0, 0, 0, 1000, 1000, 0, '0});
    send_task('{0, 0, 1, 1000, 1000, 0, '0});
    idle_then_set_limit(7'd127);
    send_task('{0, 1, 270, 1000, 1000, 0, '0});

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int n = 0; n < 225; n++) begin
        r = random_task();
        send_task(r);
      end
      case (phase)
        0: idle_then_set_limit(7'd1);
        1: idle_then_set_limit(7'd100);
        2: idle_then_set_limit(7'd90);
        default: idle_then_set_limit(7'd50);
      endcase
    end

    $display("Covered %0d fit, %0d realigned, %0d no-space and %0d error beats,",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("across limits 0 to 127 and four sender/receiver idling patterns.");
    if (failures == 0 && verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", failures, verdicts.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
